### sv/hrbp_pkg.sv
// Package for the HTTP request byte parser: payload structs, parse phase type,
// character codes and the header prefix table.
// No dependencies; every other file of the block imports it.
`default_nettype none

package hrbp_pkg;

    // Default width of the content length accumulator and body counter.
    localparam int LENGTH_BITS_DEF = 16;

    // One received byte of the request stream.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_last;
    } req_item_t;

    // One parser event.
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  byte_value;
        logic        method;
        logic [15:0] body_length;
        logic        request_done;
    } evt_item_t;

    // Event kinds.
    localparam logic [1:0] KIND_PATH  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_BODY  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Methods.
    localparam logic METHOD_GET  = 1'b0;
    localparam logic METHOD_POST = 1'b1;

    // Parse phases, one-hot.
    typedef enum logic [5:0] {
        PH_WAIT  = 6'b000001,
        PH_PATH  = 6'b000010,
        PH_QUERY = 6'b000100,
        PH_LINE  = 6'b001000,
        PH_HDR   = 6'b010000,
        PH_BODY  = 6'b100000
    } phase_t;

    // Character codes.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Method words as they appear in the recent byte window, newest lowest.
    localparam logic [31:0] GET_WORD  = 32'h4745_5420;
    localparam logic [39:0] POST_WORD = 40'h50_4F53_5420;

    // Header prefix matching.
    localparam logic [4:0] PREFIX_LEN = 5'd16;
    localparam logic [4:0] POS_DEAD   = 5'd31;

    // Characters of "Content-Length: " by position.
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h20; // space
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### sv/hrbp_core.sv
// Parse state and next-state logic of the HTTP request byte parser.
// Depends on hrbp_pkg. Updates its state on every accepted byte and
// presents the event (if any) that the byte causes in the same cycle.
`default_nettype none

module hrbp_core #(
    parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire hrbp_pkg::req_item_t item,
    output logic                   evt_fire,
    output hrbp_pkg::evt_item_t    evt
);
    import hrbp_pkg::*;

    localparam int SUM_BITS = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [39:0]            recent_reg, recent_next;
    logic [4:0]             pos_reg, pos_next;
    logic                   digits_reg, digits_next;
    logic                   empty_reg, empty_next;
    logic                   cr_reg, cr_next;
    logic                   method_reg, method_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    logic [7:0]             b;
    logic [SUM_BITS-1:0]    len_ext;
    logic [SUM_BITS-1:0]    len_sum;
    logic [LENGTH_BITS-1:0] len_digit;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [4:0]             pos_inc;
    logic [LENGTH_BITS+15:0] len_wide;

    assign b = item.data_byte;

    // Decimal step: length * 10 + digit, saturated at the all-ones maximum.
    assign len_ext = {4'b0000, len_reg};
    assign len_sum = (len_ext << 3) + (len_ext << 1)
                   + {{(SUM_BITS-4){1'b0}}, 4'(b - CH_ZERO)};
    assign len_digit = (len_sum > {4'b0000, LEN_MAX}) ? LEN_MAX
                                                      : len_sum[LENGTH_BITS-1:0];

    assign count_inc = count_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign len_wide  = {16'h0000, len_reg};

    // Next-state and event logic for one accepted byte.
    always_comb
    begin
        phase_next  = phase_reg;
        recent_next = recent_reg;
        pos_next    = pos_reg;
        digits_next = digits_reg;
        empty_next  = empty_reg;
        cr_next     = cr_reg;
        method_next = method_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        pos_inc     = pos_reg + 5'd1;

        evt_fire          = 1'b0;
        evt.event_kind    = KIND_PATH;
        evt.byte_value    = b;
        evt.method        = method_reg;
        evt.body_length   = len_wide[15:0];
        evt.request_done  = 1'b0;

        case (phase_reg)
            PH_PATH, PH_QUERY:
            begin
                if (b == CH_SP) begin
                    phase_next = PH_LINE;
                end else if (b == CH_CR) begin
                    phase_next = PH_LINE;
                    cr_next    = 1'b1;
                end else if (phase_reg == PH_PATH && b == CH_QMARK) begin
                    phase_next = PH_QUERY;
                end else begin
                    evt_fire       = 1'b1;
                    evt.event_kind = (phase_reg == PH_PATH) ? KIND_PATH : KIND_QUERY;
                end
            end

            PH_LINE:
            begin
                if (cr_reg && b == CH_LF) begin
                    phase_next  = PH_HDR;
                    empty_next  = 1'b1;
                    pos_next    = 5'd0;
                    digits_next = 1'b0;
                    cr_next     = 1'b0;
                end else begin
                    cr_next = (b == CH_CR);
                end
            end

            PH_HDR:
            begin
                if (cr_reg && b == CH_LF) begin
                    if (empty_reg) begin
                        if (len_reg == '0) begin
                            // Headers ended and there is no body.
                            phase_next       = PH_WAIT;
                            recent_next      = '0;
                            evt_fire         = 1'b1;
                            evt.event_kind   = KIND_END;
                            evt.byte_value   = 8'h00;
                            evt.request_done = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                            count_next = '0;
                        end
                    end
                    empty_next  = 1'b1;
                    pos_next    = 5'd0;
                    digits_next = 1'b0;
                    cr_next     = 1'b0;
                end else begin
                    // A carriage return not followed by a line feed is an ordinary byte.
                    if (cr_reg) begin
                        cr_next     = 1'b0;
                        empty_next  = 1'b0;
                        pos_next    = POS_DEAD;
                        digits_next = 1'b0;
                    end
                    if (b == CH_CR) begin
                        cr_next     = 1'b1;
                        digits_next = 1'b0;
                        if (pos_next != PREFIX_LEN)
                            pos_next = POS_DEAD;
                    end else begin
                        empty_next = 1'b0;
                        if (pos_next < PREFIX_LEN) begin
                            pos_inc = pos_next + 5'd1;
                            if (b == prefix_char(pos_next[3:0])) begin
                                pos_next = pos_inc;
                                if (pos_inc == PREFIX_LEN) begin
                                    digits_next = 1'b1;
                                    len_next    = '0;
                                end
                            end else begin
                                pos_next = POS_DEAD;
                            end
                        end else if (pos_next == PREFIX_LEN && digits_next) begin
                            if (b >= CH_ZERO && b <= CH_NINE)
                                len_next = len_digit;
                            else
                                digits_next = 1'b0;
                        end
                    end
                end
            end

            PH_BODY:
            begin
                count_next     = count_inc;
                evt_fire       = 1'b1;
                evt.event_kind = KIND_BODY;
                if (count_inc == len_reg) begin
                    evt.request_done = 1'b1;
                    phase_next       = PH_WAIT;
                    recent_next      = '0;
                    empty_next       = 1'b1;
                    pos_next         = 5'd0;
                    digits_next      = 1'b0;
                    cr_next          = 1'b0;
                end
            end

            default:
            begin
                // Method search over the last five bytes.
                recent_next = {recent_reg[31:0], b};
                if (recent_next[31:0] == GET_WORD || recent_next == POST_WORD) begin
                    method_next = (recent_next[31:0] == GET_WORD) ? METHOD_GET
                                                                  : METHOD_POST;
                    phase_next  = PH_PATH;
                    recent_next = '0;
                    len_next    = '0;
                    count_next  = '0;
                    empty_next  = 1'b1;
                    pos_next    = 5'd0;
                    digits_next = 1'b0;
                    cr_next     = 1'b0;
                end
            end
        endcase
    end

    // Parse state registers, updated on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_WAIT;
            recent_reg <= '0;
            pos_reg    <= 5'd0;
            digits_reg <= 1'b0;
            empty_reg  <= 1'b1;
            cr_reg     <= 1'b0;
            method_reg <= METHOD_GET;
            len_reg    <= '0;
            count_reg  <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            recent_reg <= recent_next;
            pos_reg    <= pos_next;
            digits_reg <= digits_next;
            empty_reg  <= empty_next;
            cr_reg     <= cr_next;
            method_reg <= method_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/hrbp_outq.sv
// Two-entry event queue: output register plus skid register.
// Depends on hrbp_pkg. Lets the parser take a byte while an event waits.
`default_nettype none

module hrbp_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire hrbp_pkg::evt_item_t push_item,
    output logic                     full,
    output logic                     evt_valid,
    input  wire logic                evt_stall,
    output hrbp_pkg::evt_item_t      evt_item
);
    import hrbp_pkg::*;

    evt_item_t  head_reg;
    evt_item_t  skid_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign evt_valid = (count_reg != 2'd0);
    assign evt_item  = head_reg;
    assign full      = (count_reg == 2'd2);
    assign pop       = evt_valid && !evt_stall;

    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    // Occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Payload registers; the skid entry moves up when the head is taken.
    always_ff @(posedge clk)
    begin
        if ((count_reg == 2'd0 && push) || (count_reg == 2'd1 && pop && push))
            head_reg <= push_item;
        else if (count_reg == 2'd2 && pop)
            head_reg <= skid_reg;
        if (count_reg == 2'd1 && push && !pop)
            skid_reg <= push_item;
    end

endmodule

`default_nettype wire

### sv/http_request_byte_parser_top.sv
// Top level of the HTTP request byte parser.
// Depends on hrbp_pkg, hrbp_core and hrbp_outq.
//
//   Channel | Direction | Payload     | Handshake
//   req     | in        | req_item_t  | req_valid / req_stall
//   evt     | out       | evt_item_t  | evt_valid / evt_stall
//
// One byte is taken per cycle while req_stall is low; its event, if any, is registered in the event queue.
// The parse state updates in the cycle of the transfer, so bytes follow back to back.
// A two-entry event queue holds results; req_stall rises only when both entries are full.
// Reset (rst_n low, asynchronous) returns the parser to method search and empties the queue.
`default_nettype none

module http_request_byte_parser_top #(
    parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire hrbp_pkg::req_item_t req_item,
    output logic                     evt_valid,
    input  wire logic                evt_stall,
    output hrbp_pkg::evt_item_t      evt_item
);
    import hrbp_pkg::*;

    logic      take;
    logic      fire;
    logic      q_full;
    evt_item_t core_evt;

    assign req_stall = q_full;
    assign take      = req_valid && !q_full;

    // Parser state machine.
    hrbp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (req_item),
        .evt_fire (fire),
        .evt      (core_evt)
    );

    // Event queue toward the consumer.
    hrbp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && fire),
        .push_item (core_evt),
        .full      (q_full),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_item  (evt_item)
    );

endmodule

`default_nettype wire

### sv/hrbp_checker.sv
// Port-level checks for the HTTP request byte parser, bound to the top level.
// Depends on hrbp_pkg and http_request_byte_parser_top.
`default_nettype none

module hrbp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                evt_valid,
    input wire logic                evt_stall,
    input wire hrbp_pkg::evt_item_t evt_item
);
    import hrbp_pkg::*;

    // A stalled event stays offered.
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid)
        else $error("event dropped while stalled");

    // A stalled event keeps its payload.
    a_evt_stable: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> $stable(evt_item))
        else $error("event payload changed while stalled");

    // Only a body byte or the end of headers completes a request.
    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_item.request_done |->
            evt_item.event_kind == KIND_BODY || evt_item.event_kind == KIND_END)
        else $error("request done on a path or query transfer");

    // End of headers carries no byte and always completes the request.
    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_item.event_kind == KIND_END |->
            evt_item.byte_value == 8'h00 && evt_item.request_done
            && evt_item.body_length == 16'h0000)
        else $error("malformed end of headers transfer");

    // The length is not yet known while path and query bytes flow.
    a_path_len: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt_item.event_kind == KIND_PATH
            || evt_item.event_kind == KIND_QUERY) |->
            evt_item.body_length == 16'h0000)
        else $error("nonzero length on a path or query transfer");

endmodule

bind http_request_byte_parser_top hrbp_checker u_hrbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_item  (evt_item)
);

`default_nettype wire

### test/http_request_byte_parser_top_test.sv
// Self-checking testbench for http_request_byte_parser_top.
// Depends on hrbp_pkg and the parser RTL. A small class predicts parser events from the
// accepted request bytes and checks each event transfer against them.
`default_nettype none

module http_request_byte_parser_top_test;

    import hrbp_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS_DEF) - 1;
    localparam string HDR_PREFIX = "Content-Length: ";

    // Predicts parser events byte by byte and compares them with the event channel.
    class request_parse_scoreboard;
        phase_t                     phase;
        logic [39:0]                window;
        logic [4:0]                 match_pos;
        bit                         digits_on;
        bit                         line_blank;
        bit                         cr_seen;
        logic                       method_seen;
        logic [LENGTH_BITS_DEF-1:0] content_len;
        logic [LENGTH_BITS_DEF-1:0] body_seen;
        evt_item_t                  expected_events[$];
        int                         errors;

        function new();
            errors = 0;
            method_seen = METHOD_GET;
            content_len = '0;
            body_seen = '0;
            back_to_search();
        endfunction

        function void new_line();
            line_blank = 1'b1;
            match_pos = '0;
            digits_on = 1'b0;
            cr_seen = 1'b0;
        endfunction

        function void back_to_search();
            phase = PH_WAIT;
            window = '0;
            new_line();
        endfunction

        function void push_event(logic [1:0] kind, logic [7:0] b, logic done);
            evt_item_t ev;
            ev.event_kind = kind;
            ev.byte_value = b;
            ev.method = method_seen;
            ev.body_length = 16'(content_len);
            ev.request_done = done;
            expected_events.push_back(ev);
        endfunction

        // One byte of a header line: prefix match, digit accumulation and lone CR handling.
        function void header_byte(logic [7:0] b);
            longint unsigned acc;
            if (cr_seen) begin
                // The earlier carriage return turned out to be an ordinary byte.
                cr_seen = 1'b0;
                line_blank = 1'b0;
                match_pos = POS_DEAD;
                digits_on = 1'b0;
            end
            if (b == CH_CR) begin
                cr_seen = 1'b1;
                digits_on = 1'b0;
                if (match_pos != PREFIX_LEN)
                    match_pos = POS_DEAD;
                return;
            end
            line_blank = 1'b0;
            if (match_pos < PREFIX_LEN) begin
                if (b == HDR_PREFIX[match_pos]) begin
                    match_pos++;
                    if (match_pos == PREFIX_LEN) begin
                        digits_on = 1'b1;
                        content_len = '0;
                    end
                end
                else
                    match_pos = POS_DEAD;
            end
            else if (match_pos == PREFIX_LEN && digits_on) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    acc = longint'(content_len) * 10 + longint'(b - CH_ZERO);
                    content_len = (acc > LEN_MAX) ? LEN_MAX[LENGTH_BITS_DEF-1:0]
                                                  : acc[LENGTH_BITS_DEF-1:0];
                end
                else
                    digits_on = 1'b0;
            end
        endfunction

        // Advances the parse state by one accepted byte and queues its event, if any.
        function void take_byte(req_item_t it);
            logic [7:0] b;
            b = it.data_byte;
            case (phase)
                PH_PATH, PH_QUERY:
                begin
                    if (b == CH_SP)
                        phase = PH_LINE;
                    else if (b == CH_CR) begin
                        phase = PH_LINE;
                        cr_seen = 1'b1;
                    end
                    else if (phase == PH_PATH && b == CH_QMARK)
                        phase = PH_QUERY;
                    else
                        push_event((phase == PH_PATH) ? KIND_PATH : KIND_QUERY, b, 1'b0);
                end
                PH_LINE:
                begin
                    if (cr_seen && b == CH_LF) begin
                        phase = PH_HDR;
                        new_line();
                    end
                    else
                        cr_seen = (b == CH_CR);
                end
                PH_HDR:
                begin
                    if (cr_seen && b == CH_LF) begin
                        if (!line_blank)
                            new_line();
                        else if (content_len == 0) begin
                            push_event(KIND_END, 8'h00, 1'b1);
                            back_to_search();
                        end
                        else begin
                            phase = PH_BODY;
                            body_seen = '0;
                        end
                    end
                    else
                        header_byte(b);
                end
                PH_BODY:
                begin
                    body_seen = body_seen + 1'b1;
                    if (body_seen == content_len) begin
                        push_event(KIND_BODY, b, 1'b1);
                        back_to_search();
                    end
                    else
                        push_event(KIND_BODY, b, 1'b0);
                end
                default:
                begin
                    // Method search over the last five bytes, newest lowest.
                    window = {window[31:0], b};
                    if (window[31:0] == GET_WORD)
                        method_seen = METHOD_GET;
                    else if (window == POST_WORD)
                        method_seen = METHOD_POST;
                    else
                        return;
                    phase = PH_PATH;
                    window = '0;
                    content_len = '0;
                    body_seen = '0;
                    new_line();
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_event(evt_item_t got);
            evt_item_t want;
            if (expected_events.size() == 0) begin
                $display("%0t: event with none expected, actual kind %0h byte %0h",
                         $time, got.event_kind, got.byte_value);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
            compare_field("byte_value", 16'(want.byte_value), 16'(got.byte_value));
            compare_field("method", 16'(want.method), 16'(got.method));
            compare_field("body_length", want.body_length, got.body_length);
            compare_field("request_done", 16'(want.request_done), 16'(got.request_done));
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item = '0;
    logic      evt_valid;
    logic      evt_stall = 1'b0;
    evt_item_t evt_item;

    request_parse_scoreboard sb;
    req_item_t               stream_q[$];
    int                      idle_cycles = 0;
    int                      stall_mode = 0;
    int                      stall_left = 0;

    http_request_byte_parser_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_item  (evt_item)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Byte stream building.
    function automatic void put(input logic [7:0] b);
        req_item_t it;
        it.data_byte = b;
        it.chunk_last = ($urandom_range(0, 7) == 0);
        stream_q.push_back(it);
    endfunction

    function automatic void put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic void end_line();
        put(CH_CR);
        put(CH_LF);
    endfunction

    function automatic logic [7:0] other_byte(input logic [7:0] x, y, z);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == x || b == y || b == z);
        return b;
    endfunction

    // Appends one request with random content. A forced length, when not negative, goes
    // into a last well-formed length header; very long bodies are cut short.
    function automatic void add_request(input int forced_len);
        int    len;
        int    v;
        string digits;
        len = 0;
        // Noise and broken methods ahead of the real one.
        case ($urandom_range(0, 5))
            0: put_text("GE");
            1: put_text("POS");
            2: put(8'($urandom));
            3: put_text("GXT ");
            default: ;
        endcase
        if ($urandom_range(0, 1) == 0)
            put_text("GET ");
        else
            put_text("POST ");
        repeat ($urandom_range(0, 6))
            put(other_byte(CH_SP, CH_CR, CH_QMARK));
        if ($urandom_range(0, 2) == 0) begin
            put(CH_QMARK);
            repeat ($urandom_range(0, 5))
                put(other_byte(CH_SP, CH_CR, CH_SP));
        end
        // Rest of the request line, sometimes with a lone carriage return.
        if ($urandom_range(0, 3) != 0) begin
            put(CH_SP);
            put_text("HTTP/1.1");
            if ($urandom_range(0, 3) == 0) begin
                put(CH_CR);
                put(other_byte(CH_CR, CH_LF, CH_CR));
            end
        end
        end_line();
        // Header lines.
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 6))
                0, 1:
                begin
                    v = $urandom_range(0, 12);
                    digits = $sformatf("%0d", v);
                    if ($urandom_range(0, 4) == 0)
                        digits = {"00", digits};
                    put_text(HDR_PREFIX);
                    put_text(digits);
                    if ($urandom_range(0, 3) == 0)
                        put_text("x9");
                    len = v;
                end
                2:
                begin
                    put_text(HDR_PREFIX);
                    put_text("abc");
                    len = 0;
                end
                3: put_text("content-length: 5");
                4:
                begin
                    put_text("Host: ");
                    repeat ($urandom_range(1, 4))
                        put(other_byte(CH_CR, CH_LF, CH_CR));
                end
                5:
                begin
                    put_text("Content");
                    put(CH_CR);
                    put_text("-Length: 4");
                end
                default: put(CH_CR);
            endcase
            end_line();
        end
        if (forced_len >= 0) begin
            put_text(HDR_PREFIX);
            put_text($sformatf("%0d", forced_len));
            end_line();
            len = (forced_len > 65535) ? 40 : forced_len;
        end
        end_line();
        repeat (len)
            put(8'($urandom));
    endfunction

    // Sends the queued bytes in bursts of random length with random gaps between them.
    task automatic drive_stream();
        req_item_t it;
        int        burst;
        int        gap;
        burst = 0;
        while (stream_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 32);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                if (gap > 0) begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            it = stream_q.pop_front();
            req_valid <= 1'b1;
            req_item <= it;
            do
                @(posedge clk);
            while (req_stall);
            burst--;
        end
        req_valid <= 1'b0;
    endtask

    // Receiver stall, switching between free, light, heavy and periodic stretches.
    always @(posedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0: evt_stall <= 1'b0;
            1: evt_stall <= ($urandom_range(0, 3) == 0);
            2: evt_stall <= ($urandom_range(0, 9) < 7);
            default: evt_stall <= stall_left[2];
        endcase
    end

    // Transfer monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && !req_stall)
                sb.take_byte(req_item);
            if (evt_valid && !evt_stall)
                sb.check_event(evt_item);
            if ((req_valid && !req_stall) || (evt_valid && !evt_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes around a POST with path, query and CR end, then a GET
        // found after a false start. Both have no body.
        put(8'h00);
        put(8'hFF);
        put_text("POST ");
        put(8'hFF);
        put(CH_QMARK);
        put(8'h00);
        end_line();
        end_line();
        put_text("GGET /");
        put(CH_SP);
        end_line();
        end_line();
        drive_stream();

        // Let the parser drain completely before the random part, once the monitor has
        // noted the last transfer.
        @(posedge clk);
        while (sb.expected_events.size() != 0)
            @(posedge clk);

        // Random requests, at most one with a longer body, and a saturated length at the end.
        while (stream_q.size() < 1500) begin
            if (stream_q.size() > 700 && stream_q.size() < 760)
                add_request($urandom_range(100, 400));
            else
                add_request(-1);
        end
        add_request(99999999);
        drive_stream();

        @(posedge clk);
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.expected_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
